### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check macros for the value scan and refine block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MVSF_CHECK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MVSF_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mvsf_pkg.sv
// ----------------------------------------------------------------------------
// mvsf_pkg
// Types, codes and helpers of the memory value scan and refine block.
// ----------------------------------------------------------------------------
package mvsf_pkg;

  localparam int ADDR_W      = 48;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 8;
  localparam int HIT_COUNT_W = 9;
  localparam int CFG_IDX_W   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_VALUE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE    = CFG_IDX_W'(1);

  // element size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_SCAN   = 2'd1,
    FUNC_REFINE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SIZE  = 2'd1,
    STAT_PASS  = 2'd2,
    STAT_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [ADDR_W-1:0]  elem_address;
    logic [INDEX_W-1:0] entry_index;
    logic [VALUE_W-1:0] mem_value;
    logic               last;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [HIT_COUNT_W-1:0] hit_count;
    logic [ADDR_W-1:0]      entry_address;
    logic                   table_full;
  } rsp_t;

  // Compare on the low bytes that the element size covers.
  function automatic logic value_match(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b,
                                       input logic [1:0] code);
    logic eq;
    case (code)
      SIZE_BYTE: eq = (a[7:0] == b[7:0]);
      SIZE_HALF: eq = (a[15:0] == b[15:0]);
      default:   eq = (a == b);
    endcase
    return eq;
  endfunction

endpackage

### hw/rtl/mvsf_ram.sv
// ----------------------------------------------------------------------------
// mvsf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mvsf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mvsf_outq.sv
// ----------------------------------------------------------------------------
// mvsf_outq
// Two-entry response buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module mvsf_outq import mvsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t push_data,
  output logic full,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic out_valid;
  logic skid_valid;
  rsp_t out_q;
  rsp_t skid_q;
  logic take;
  logic out_free;

  assign take      = out_valid && rsp_ready;
  assign out_free  = !out_valid || take;
  assign full      = skid_valid;
  assign rsp_valid = out_valid;
  assign rsp       = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // advance payload: skid drains first, new response fills the free slot
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= push_data;
      end
    end
    if (push && (skid_valid || !out_free)) begin
      skid_q <= push_data;
    end
  end

endmodule

### hw/rtl/memory_value_scan_filter_unit.sv
// ----------------------------------------------------------------------------
// memory_value_scan_filter_unit
// Hit table for a memory value search: fresh scan, refine with stable
// compaction into ascending address order, and entry readback.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (write only)
//  req     | req_valid / req_ready | req_t: func, address, index, value
//  rsp     | rsp_valid / rsp_ready | rsp_t: status, count, address, full
//
//  Clear, scan, refine and error requests: response registered.
//  Entry read: registered read of the hit RAM, response built in ST_READ.
//  Last refine: answers after a compaction walk through ST_SCAN, ST_LOAD, ST_SHIFT
//    and ST_PUT; insertion moves number at most kept * (kept - 1) / 2.
//  req_ready is low while a request is in work or the skid stage is full.
//  Synchronous reset; neither RAM is reset, a flag clears when its entry is written.
//
`include "assert_macros.svh"

module memory_value_scan_filter_unit import mvsf_pkg::*; #(
  parameter int MAX_HITS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp
);

  localparam int CNT_W   = $clog2(MAX_HITS + 1);
  localparam int IDX_W   = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
  localparam logic [CNT_W-1:0] MAX_LIM  = CNT_W'(MAX_HITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_LOAD,
    ST_SHIFT,
    ST_PUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRESH,
    MODE_REFINE
  } mode_t;

  state_t state;
  mode_t  mode;

  // configuration
  logic [VALUE_W-1:0] search_value;
  logic [1:0]         elem_size;

  // table bookkeeping
  logic [CNT_W-1:0]  hit_total;
  logic [1:0]        slot_size;

  // compaction walk
  logic [CNT_W-1:0]  wi;
  logic [CNT_W-1:0]  kept;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  jm1;
  logic [ADDR_W-1:0] ins_addr;
  logic              keep_bit;

  // RAM ports
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ADDR_W-1:0] wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] rd_data;

  // keep flag RAM ports
  logic              kwr_en;
  logic [IDX_W-1:0]  kwr_addr;
  logic              kwr_data;
  logic [IDX_W-1:0]  krd_addr;

  // request decode
  logic             accept;
  logic             size_bad;
  logic             match;
  logic             idx_ok;
  logic             scan_pass_err;
  logic             fresh_go;
  logic             fresh_hit;
  logic             refine_go;
  logic             read_go;
  logic [CNT_W-1:0] total_fresh;
  logic [1:0]       size_tag;

  // response path
  logic res_push;
  rsp_t res;
  logic q_full;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == ST_IDLE) && !q_full;
  assign accept    = req_valid && req_ready;

  assign size_tag      = elem_size + 2'd1;
  assign size_bad      = (elem_size == 2'd3) || (slot_size != 2'd0 && slot_size != size_tag);
  assign match         = value_match(req.mem_value, search_value, elem_size);
  assign idx_ok        = CMP_W'(req.entry_index) < CMP_W'(hit_total);
  assign scan_pass_err = (mode == MODE_REFINE) || (hit_total != '0 && mode != MODE_FRESH);
  assign jm1           = j - ONE;

  // Decode the request, steer the RAM ports and build the response.
  always_comb begin
    fresh_go    = 1'b0;
    fresh_hit   = 1'b0;
    refine_go   = 1'b0;
    read_go     = 1'b0;
    total_fresh = hit_total;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = req.elem_address;
    rd_addr     = IDX_W'(req.entry_index);
    kwr_en      = 1'b0;
    kwr_addr    = IDX_W'(wi);
    kwr_data    = 1'b0;
    krd_addr    = IDX_W'(wi);
    res_push    = 1'b0;
    res.status        = STAT_OK;
    res.hit_count     = HIT_COUNT_W'(hit_total);
    res.entry_address = '0;
    res.table_full    = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_push = 1'b1;
          case (req.func)
            FUNC_CLEAR: begin
              res.hit_count = '0;
            end
            FUNC_SCAN: begin
              if (scan_pass_err) begin
                res.status = STAT_PASS;
              end else if (size_bad) begin
                res.status = STAT_SIZE;
              end else begin
                fresh_go    = 1'b1;
                // drop elements once the table is full
                fresh_hit   = (hit_total < MAX_LIM) && match;
                total_fresh = hit_total + CNT_W'(fresh_hit);
                wr_en       = fresh_hit;
                wr_addr     = IDX_W'(hit_total);
                // a new entry starts with its keep flag low
                kwr_en      = fresh_hit;
                kwr_addr    = IDX_W'(hit_total);
                res.hit_count  = HIT_COUNT_W'(total_fresh);
                res.table_full = (total_fresh >= MAX_LIM);
              end
            end
            FUNC_REFINE: begin
              if (hit_total == '0 || mode == MODE_FRESH) begin
                res.status = STAT_PASS;
              end else if (size_bad) begin
                res.status = STAT_SIZE;
              end else if (!idx_ok) begin
                res.status = STAT_INDEX;
              end else begin
                refine_go = 1'b1;
                kwr_en    = 1'b1;
                kwr_addr  = IDX_W'(req.entry_index);
                kwr_data  = match;
                // the last request answers after compaction
                res_push  = !req.last;
              end
            end
            FUNC_READ: begin
              if (!idx_ok) begin
                res.status = STAT_INDEX;
              end else begin
                read_go  = 1'b1;
                res_push = 1'b0;
              end
            end
            default: begin
              res.status = STAT_OK;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push          = 1'b1;
        res.entry_address = rd_data;
      end
      ST_SCAN: begin
        // fetch entry wi and its flag, and drop the flag as the walk passes
        rd_addr = IDX_W'(wi);
        if (wi == hit_total) begin
          res_push      = 1'b1;
          res.hit_count = HIT_COUNT_W'(kept);
        end else begin
          kwr_en = 1'b1;
        end
      end
      ST_LOAD: begin
        // first kept entry goes straight to slot zero
        rd_addr = IDX_W'(kept - ONE);
        wr_data = rd_data;
        wr_en   = keep_bit && (kept == '0);
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(j);
        rd_addr = IDX_W'(jm1 - ONE);
        // move a larger address up one slot, or drop the new one in place
        wr_data = (rd_data > ins_addr) ? rd_data : ins_addr;
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(j);
        wr_data = ins_addr;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= MODE_IDLE;
      search_value <= '0;
      elem_size    <= SIZE_WORD;
      hit_total    <= '0;
      slot_size    <= 2'd0;
      wi           <= '0;
      kept         <= '0;
      j            <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SEARCH_VALUE: search_value <= cfg_data;
          REG_ELEM_SIZE:    elem_size    <= cfg_data[1:0];
          default:          ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.func)
              FUNC_CLEAR: begin
                mode      <= MODE_IDLE;
                hit_total <= '0;
                slot_size <= 2'd0;
              end
              FUNC_SCAN: begin
                if (fresh_go) begin
                  mode      <= req.last ? MODE_IDLE : MODE_FRESH;
                  slot_size <= size_tag;
                  hit_total <= total_fresh;
                end
              end
              FUNC_REFINE: begin
                if (refine_go) begin
                  mode <= MODE_REFINE;
                  if (req.last) begin
                    wi    <= '0;
                    kept  <= '0;
                    state <= ST_SCAN;
                  end
                end
              end
              FUNC_READ: begin
                if (read_go) begin
                  state <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (wi == hit_total) begin
            hit_total <= kept;
            mode      <= MODE_IDLE;
            state     <= ST_IDLE;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (!keep_bit) begin
            wi    <= wi + ONE;
            state <= ST_SCAN;
          end else if (kept == '0) begin
            kept  <= kept + ONE;
            wi    <= wi + ONE;
            state <= ST_SCAN;
          end else begin
            j     <= kept;
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (rd_data > ins_addr) begin
            j <= jm1;
            if (jm1 == '0) begin
              state <= ST_PUT;
            end
          end else begin
            kept  <= kept + ONE;
            wi    <= wi + ONE;
            state <= ST_SCAN;
          end
        end
        ST_PUT: begin
          kept  <= kept + ONE;
          wi    <= wi + ONE;
          state <= ST_SCAN;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the address being inserted during the walk
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      ins_addr <= rd_data;
    end
  end

  mvsf_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_HITS)
  ) u_hit_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mvsf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_HITS)
  ) u_keep_ram (
    .clk   (clk),
    .we    (kwr_en),
    .waddr (kwr_addr),
    .wdata (kwr_data),
    .raddr (krd_addr),
    .rdata (keep_bit)
  );

  mvsf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (q_full),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `MVSF_CHECK_NOW(a_total_bound, clk, rst, 1'b1, hit_total <= MAX_LIM, "hit total above depth")
  `MVSF_CHECK_NEXT(a_clear_empties, clk, rst, accept && req.func == FUNC_CLEAR, hit_total == '0 && slot_size == 2'd0 && mode == MODE_IDLE, "clear left state behind")
  `MVSF_CHECK_NOW(a_walk_order, clk, rst, state == ST_SCAN || state == ST_LOAD || state == ST_SHIFT || state == ST_PUT, kept <= wi && wi <= hit_total, "compaction overran")
  `MVSF_CHECK_NOW(a_no_overrun, clk, rst, res_push, !q_full, "response pushed into full buffer")

endmodule
